FILE: rtl/trl_pkg.sv
package trl_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int ID_W            = 16;
    localparam int HANDLE_W        = 16;
    localparam int COUNT_OUT_W     = 6;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ID_W-1:0]     thread_id;
        logic [HANDLE_W-1:0] handle_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_W-1:0]    handle_out;
        logic                   is_empty;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic cmp_en;
        logic load_en;
        logic shift_en;
    } t_cell_ctl;

endpackage

FILE: rtl/trl_cell.sv
module trl_cell (
    input  logic                      i_clk,
    input  trl_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_valid,
    input  logic [trl_pkg::ID_W-1:0]  i_cmp_id,
    input  trl_pkg::t_entry           i_new,
    input  trl_pkg::t_entry           i_next,
    output trl_pkg::t_entry           o_entry,
    output logic                      o_hit
);

    trl_pkg::t_entry r_entry;
    logic            r_hit;

    // slot content and its registered id match
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_hit <= i_valid && (r_entry.id == i_cmp_id);
        end
        if (i_ctl.load_en) begin
            r_entry <= i_new;
        end else if (i_ctl.shift_en) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

FILE: rtl/thread_ready_list_core.sv
// Ordered list of up to MAX_ENTRIES thread entries (16-bit id, 16-bit handle),
// front at cell 0. Opcode 0 appends at the rear (status full when no slot is
// free), opcode 1 removes the first entry from the front with a matching id and
// closes the gap so the order of the rest is kept, opcode 2 looks up the first
// match without changing the list, opcode 3 does nothing. Every transaction
// gives one result with status, handle (zero unless found), empty flag and the
// count after the step (count modulo 64). The request is latched at the edge
// that accepts it. In the next cycle every cell compares its id in parallel and
// registers a hit (state S_SEARCH). In state S_APPLY, once the result register
// is free, a prefix-OR over the hit row picks the first match, the handle is
// selected, the tail cells all move forward by one at once and the result
// register loads. No new transaction is taken before that. The next
// transaction is taken the cycle after the result is registered, even while
// that result is still stalled downstream; the update cycle itself waits when
// the result register is still occupied and stalled.
module thread_ready_list_core #(
    parameter int MAX_ENTRIES = trl_pkg::MAX_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  trl_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output trl_pkg::t_out_item o_out_item
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int LG = $clog2(MAX_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY
    } t_state;

    t_state             r_state, n_state;
    trl_pkg::t_in_item  r_item;
    logic [CW-1:0]      r_count, n_count;
    logic               r_out_valid, n_out_valid;
    trl_pkg::t_out_item r_out_item, n_out_item;

    trl_pkg::t_cell_ctl                    cell_ctl [MAX_ENTRIES];
    trl_pkg::t_entry                       cell_ent [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]                hits;
    logic [LG:0][MAX_ENTRIES-1:0]          pre;
    logic [MAX_ENTRIES-1:0]                first_hit;
    logic                                  found;
    logic [trl_pkg::HANDLE_W-1:0]          sel_handle;
    logic                                  out_free;
    logic                                  apply;
    logic                                  accept;
    trl_pkg::t_entry                       new_ent;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign apply    = (r_state == S_APPLY) && out_free;
    assign new_ent  = '{id: r_item.thread_id, handle: r_item.handle_in};

    // row of cells, each taking its rear neighbor's entry on a shift
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        trl_pkg::t_entry next_ent;
        logic            tail_move;

        if (k == MAX_ENTRIES - 1) begin : g_last
            assign next_ent = new_ent;
        end else begin : g_mid
            assign next_ent = cell_ent[k+1];
        end

        // cell moves when at or behind the first match and not the last valid entry
        assign tail_move = pre[LG][k] && ((CW+1)'(k + 1) < {1'b0, r_count});

        assign cell_ctl[k] = '{
            cmp_en:   (r_state == S_SEARCH),
            load_en:  apply && (r_item.opcode == trl_pkg::OP_APPEND)
                      && ((CW+1)'(k) == {1'b0, r_count}),
            shift_en: apply && (r_item.opcode == trl_pkg::OP_REMOVE) && tail_move
        };

        trl_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (cell_ctl[k]),
            .i_valid  ((CW+1)'(k) < {1'b0, r_count}),
            .i_cmp_id (r_item.thread_id),
            .i_new    (new_ent),
            .i_next   (next_ent),
            .o_entry  (cell_ent[k]),
            .o_hit    (hits[k])
        );
    end

    // log-depth inclusive prefix OR over the hit row
    assign pre[0] = hits;
    for (genvar l = 0; l < LG; l++) begin : g_lvl
        for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_bit
            if (k >= (1 << l)) begin : g_or
                assign pre[l+1][k] = pre[l][k] | pre[l][k - (1 << l)];
            end else begin : g_pass
                assign pre[l+1][k] = pre[l][k];
            end
        end
    end

    // first match: hit with no hit in front of it
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_first
        if (k == 0) begin : g_front
            assign first_hit[k] = hits[k];
        end else begin : g_rest
            assign first_hit[k] = hits[k] && !pre[LG][k-1];
        end
    end

    assign found = pre[LG][MAX_ENTRIES-1];

    // one-hot handle select
    always_comb begin
        sel_handle = '0;
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            sel_handle = sel_handle
                         | ({trl_pkg::HANDLE_W{first_hit[k]}} & cell_ent[k].handle);
        end
    end

    always_comb begin
        logic [1:0]                   status;
        logic [trl_pkg::HANDLE_W-1:0] handle;

        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        status      = trl_pkg::ST_OK;
        handle      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) begin
                    case (r_item.opcode)
                        trl_pkg::OP_APPEND: begin
                            if (r_count == CW'(MAX_ENTRIES)) begin
                                status = trl_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        trl_pkg::OP_REMOVE: begin
                            if (found) begin
                                handle  = sel_handle;
                                n_count = r_count - CW'(1);
                            end else begin
                                status = trl_pkg::ST_NOT_FOUND;
                            end
                        end
                        trl_pkg::OP_LOOKUP: begin
                            if (found) begin
                                handle = sel_handle;
                            end else begin
                                status = trl_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            status = trl_pkg::ST_OK;
                        end
                    endcase
                    n_out_valid            = 1'b1;
                    n_out_item.status      = status;
                    n_out_item.handle_out  = handle;
                    n_out_item.is_empty    = (n_count == '0);
                    n_out_item.entry_count = trl_pkg::COUNT_OUT_W'(n_count);
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        if (accept) begin
            r_item <= i_in_item;
        end
        r_out_item <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/trl_checker.sv
module trl_checker #(
    parameter int MAX_ENTRIES = trl_pkg::MAX_ENTRIES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input trl_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input trl_pkg::t_out_item o_out_item
);

    localparam logic [trl_pkg::COUNT_OUT_W-1:0] MAX_CNT =
        trl_pkg::COUNT_OUT_W'(MAX_ENTRIES);
    localparam logic SMALL = (MAX_ENTRIES < 64);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // full is only reported with the list at capacity and no handle
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == trl_pkg::ST_FULL)
        |-> (o_out_item.entry_count == MAX_CNT) && (o_out_item.handle_out == '0))
        else $error("full result inconsistent");

    // a miss carries no handle
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == trl_pkg::ST_NOT_FOUND)
        |-> (o_out_item.handle_out == '0))
        else $error("miss with handle");

    // empty flag agrees with the count, and the count stays within capacity (lists under 64 entries)
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && SMALL
        |-> (o_out_item.is_empty == (o_out_item.entry_count == '0))
            && (o_out_item.entry_count <= MAX_CNT))
        else $error("empty flag or count out of range");

    // after a transaction is taken, the input stalls through the search and the first try of the update
    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall)
        else $error("transaction taken while one is open");

endmodule

bind thread_ready_list_core trl_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_trl_checker (.*);

FILE: bench/thread_ready_list_core_tb.sv
module thread_ready_list_core_tb;
    import trl_pkg::*;

    localparam int LIST_DEPTH    = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int DRAIN_CYCLES  = 12;

    // opcode 3 has no package name: the block treats it as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;

    // traffic mix of one random phase
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    typedef struct packed {
        t_in_item  req;
        bit        typed;
        t_out_item res;
    } t_directed_row;

    // clock, reset and channel signals; those driven here are known from time zero
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    // shadow copy of the list, front at slot 0
    logic [ID_W-1:0]     list_ids     [LIST_DEPTH];
    logic [HANDLE_W-1:0] list_handles [LIST_DEPTH];
    int                  list_fill = 0;

    // results still owed by the block, oldest first
    t_out_item expected_results[$];
    t_directed_row directed_rows[$];

    int  mismatch_count = 0;
    int  checked_count  = 0;
    int  sent_count     = 0;
    int  full_refusals  = 0;
    int  miss_count     = 0;
    int  drained_count  = 0;
    int  quiet_cycles   = 0;
    int  stall_hold     = 0;
    bit  no_idle        = 1'b0;

    thread_ready_list_core #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    always #4 clk = ~clk;

    // gap length for either side: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // applies one transaction to the shadow list and returns its result
    function automatic t_out_item step_ready_list(input t_in_item req);
        t_out_item res;
        int        pos;
        res = '0;
        res.status = ST_OK;
        pos = -1;
        case (req.opcode)
            OP_APPEND: begin
                if (list_fill >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_ids[list_fill]     = req.thread_id;
                    list_handles[list_fill] = req.handle_in;
                    list_fill++;
                end
            end
            OP_REMOVE, OP_LOOKUP: begin
                // first match from the front wins when ids repeat
                for (int i = 0; i < list_fill; i++)
                    if (pos < 0 && list_ids[i] == req.thread_id) pos = i;
                if (pos < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.handle_out = list_handles[pos];
                    if (req.opcode == OP_REMOVE) begin
                        // close the gap, order of the tail is kept
                        for (int i = pos; i < list_fill - 1; i++) begin
                            list_ids[i]     = list_ids[i + 1];
                            list_handles[i] = list_handles[i + 1];
                        end
                        list_fill--;
                    end
                end
            end
            default: ;
        endcase
        res.is_empty    = (list_fill == 0);
        res.entry_count = list_fill[COUNT_OUT_W-1:0];
        return res;
    endfunction

    // id with a bias toward a tiny pool (duplicates) and the extremes
    function automatic logic [ID_W-1:0] fresh_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return ID_W'($urandom_range(0, 7));
        if (r == 4) return '0;
        if (r == 5) return '1;
        return ID_W'($urandom);
    endfunction

    function automatic t_in_item pick_request(input int phase);
        t_in_item req;
        int       r;
        int       n_app, n_rem, n_look;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  begin n_app = 85; n_rem = 93; n_look = 98; end
            PH_DRAIN: begin n_app = 10; n_rem = 80; n_look = 97; end
            default:  begin n_app = 40; n_rem = 70; n_look = 95; end
        endcase
        if (r < n_app)       req.opcode = OP_APPEND;
        else if (r < n_rem)  req.opcode = OP_REMOVE;
        else if (r < n_look) req.opcode = OP_LOOKUP;
        else                 req.opcode = OP_NOP;
        req.handle_in = HANDLE_W'($urandom);
        // removes and lookups mostly aim at an id that is really held
        if (req.opcode != OP_APPEND && list_fill > 0 && $urandom_range(0, 3) != 0)
            req.thread_id = list_ids[$urandom_range(0, list_fill - 1)];
        else
            req.thread_id = fresh_id();
        return req;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [ID_W-1:0] id,
                                    input logic [HANDLE_W-1:0] h, input bit typed,
                                    input logic [1:0] st, input logic [HANDLE_W-1:0] ho,
                                    input logic emp, input int cnt);
        t_directed_row row;
        row.req.opcode       = op;
        row.req.thread_id    = id;
        row.req.handle_in    = h;
        row.typed            = typed;
        row.res.status       = st;
        row.res.handle_out   = ho;
        row.res.is_empty     = emp;
        row.res.entry_count  = COUNT_OUT_W'(cnt);
        directed_rows.push_back(row);
    endfunction

    // drives one transaction, holds it through stalls, records what it should yield
    task automatic offer_request(input t_in_item req, input bit typed,
                                 input t_out_item typed_res);
        t_out_item predicted;
        int        gap;
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        predicted = step_ready_list(req);
        expected_results.push_back(typed ? typed_res : predicted);
        sent_count++;
        if (predicted.status == ST_FULL) full_refusals++;
        if (predicted.status == ST_NOT_FOUND) miss_count++;
        if (req.opcode == OP_REMOVE && predicted.status == ST_OK && predicted.is_empty)
            drained_count++;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver back-pressure, held for a random number of cycles
    always @(posedge clk) begin
        int len;
        if (stall_hold > 0) begin
            out_stall  <= 1'b1;
            stall_hold <= stall_hold - 1;
        end else begin
            len = idle_len();
            out_stall  <= (len > 0);
            stall_hold <= (len > 0) ? len - 1 : 0;
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status %0d handle %h empty %0d count %0d",
                         $time, out_item.status, out_item.handle_out,
                         out_item.is_empty, out_item.entry_count);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (out_item.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, out_item.status);
                    mismatch_count++;
                end
                if (out_item.handle_out !== want.handle_out) begin
                    $display("%0t: handle_out expected %h got %h",
                             $time, want.handle_out, out_item.handle_out);
                    mismatch_count++;
                end
                if (out_item.is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0d got %0d",
                             $time, want.is_empty, out_item.is_empty);
                    mismatch_count++;
                end
                if (out_item.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d got %0d",
                             $time, want.entry_count, out_item.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_results.size());
                $display("** thread_ready_list_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        int n_random;
        int phase;
        int phase_len;

        // directed table: typed results where they are obvious, predictor elsewhere
        add_row(OP_LOOKUP, 16'h0000, 16'h0000, 1, ST_NOT_FOUND, 16'h0000, 1, 0);
        add_row(OP_REMOVE, 16'hFFFF, 16'hFFFF, 1, ST_NOT_FOUND, 16'h0000, 1, 0);
        add_row(OP_NOP,    16'hFFFF, 16'hFFFF, 1, ST_OK,        16'h0000, 1, 0);
        add_row(OP_APPEND, 16'h0000, 16'hFFFF, 1, ST_OK,        16'h0000, 0, 1);
        add_row(OP_APPEND, 16'hFFFF, 16'h0000, 1, ST_OK,        16'h0000, 0, 2);
        // duplicate id is allowed
        add_row(OP_APPEND, 16'h0000, 16'h1234, 1, ST_OK,        16'h0000, 0, 3);
        add_row(OP_LOOKUP, 16'h0000, 16'h0000, 1, ST_OK,        16'hFFFF, 0, 3);
        add_row(OP_LOOKUP, 16'hFFFF, 16'hAAAA, 1, ST_OK,        16'h0000, 0, 3);
        add_row(OP_REMOVE, 16'h0000, 16'h0000, 1, ST_OK,        16'hFFFF, 0, 2);
        add_row(OP_LOOKUP, 16'h0000, 16'h0000, 1, ST_OK,        16'h1234, 0, 2);
        add_row(OP_REMOVE, 16'h0007, 16'h0000, 1, ST_NOT_FOUND, 16'h0000, 0, 2);
        add_row(OP_NOP,    16'h0000, 16'h0000, 1, ST_OK,        16'h0000, 0, 2);
        add_row(OP_APPEND, 16'h5555, 16'hAAAA, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_APPEND, 16'hAAAA, 16'h5555, 0, ST_OK, 16'h0000, 0, 0);
        // removal from the front, then check the tail moved up in order
        add_row(OP_REMOVE, 16'hFFFF, 16'h0000, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_LOOKUP, 16'hAAAA, 16'h0000, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_REMOVE, 16'h0000, 16'hFFFF, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_REMOVE, 16'hAAAA, 16'h0000, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_REMOVE, 16'h5555, 16'h0000, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_REMOVE, 16'h5555, 16'h0000, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_APPEND, 16'hFFFF, 16'hFFFF, 0, ST_OK, 16'h0000, 0, 0);
        add_row(OP_REMOVE, 16'hFFFF, 16'h0000, 0, ST_OK, 16'h0000, 0, 0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].res);

        // random part in phases biased toward filling, toward draining, or mixed
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            phase     = $urandom_range(PH_FILL, PH_MIXED);
            phase_len = $urandom_range(30, 70);
            no_idle  <= ($urandom_range(0, 4) == 0);
            for (int k = 0; k < phase_len && n_random < RANDOM_ITEMS; k++) begin
                offer_request(pick_request(phase), 1'b0, '0);
                n_random++;
            end
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions sent (%0d from the table), %0d results checked",
                 sent_count, directed_rows.size(), checked_count);
        $display("appends refused on a full list: %0d, unmatched removes/lookups: %0d,",
                 full_refusals, miss_count);
        $display("removes that drained the list to empty: %0d", drained_count);
        if (mismatch_count == 0) begin
            $display("** thread_ready_list_core: PASSED **");
        end else begin
            $display("** thread_ready_list_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: thread_ready_list_core.f
rtl/trl_pkg.sv
rtl/trl_cell.sv
rtl/thread_ready_list_core.sv
rtl/trl_checker.sv
bench/thread_ready_list_core_tb.sv
